@@ src/sacl_pkg.sv @@
// Shared types, codes and default parameters of the set-associative LRU cache model.
package sacl_pkg;

    localparam int DEF_MAX_SET_BITS = 6;
    localparam int DEF_MAX_WAYS     = 8;
    localparam int DEF_ADDR_WIDTH   = 32;

    localparam int TAG_W   = 32;
    localparam int STAMP_W = 32;
    localparam int CNT_W   = 32;
    localparam int ENTRY_W = 1 + TAG_W + STAMP_W;

    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_STORE  = 2'd1;
    localparam logic [1:0] MODE_MODIFY = 2'd2;

    localparam logic [1:0] CFG_SET_BITS    = 2'd0;
    localparam logic [1:0] CFG_BLOCK_BITS  = 2'd1;
    localparam logic [1:0] CFG_WAYS_IN_USE = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] address;
    } req_t;

    typedef struct packed {
        logic             first_hit;
        logic             evicted;
        logic             second_hit;
        logic [CNT_W-1:0] hit_total;
        logic [CNT_W-1:0] miss_total;
        logic [CNT_W-1:0] eviction_total;
    } rsp_t;

    typedef struct packed {
        logic               valid;
        logic [TAG_W-1:0]   tag;
        logic [STAMP_W-1:0] stamp;
    } line_entry_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP
    } sacl_state_t;

endpackage

@@ src/sacl_set_mem.sv @@
// Set store: one row per set, one write port and one registered read port.
module sacl_set_mem #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 520
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/sacl_way_select.sv @@
// Way compare and LRU victim tree over one set row.
module sacl_way_select #(
    parameter int MAX_WAYS = sacl_pkg::DEF_MAX_WAYS,
    parameter int CNT_W    = $clog2(MAX_WAYS + 1),
    parameter int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1
) (
    input  sacl_pkg::line_entry_t [MAX_WAYS-1:0] row,
    input  logic [sacl_pkg::TAG_W-1:0]            tag,
    input  logic [CNT_W-1:0]                      ways,
    output logic                                  hit,
    output logic [WAY_W-1:0]                      hit_way,
    output logic [WAY_W-1:0]                      victim_way,
    output logic                                  victim_used
);

    localparam int LEVELS = $clog2(MAX_WAYS);
    localparam int LEAVES = 1 << LEVELS;
    localparam int PAD_W  = LEAVES * sacl_pkg::ENTRY_W;

    sacl_pkg::line_entry_t [LEAVES-1:0] pad_row;
    logic                        node_en    [1:2*LEAVES-1];
    logic [sacl_pkg::STAMP_W-1:0] node_stamp [1:2*LEAVES-1];
    logic [WAY_W-1:0]            node_way   [1:2*LEAVES-1];

    // Lowest matching way wins; scan high to low so the last write is the lowest.
    always_comb
    begin
        hit     = 1'b0;
        hit_way = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--)
        begin
            if (row[w].valid && (row[w].tag == tag) && (CNT_W'(w) < ways))
            begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
        end
    end

    // Min tree: the left child has the lower way, so take the right only when strictly older.
    always_comb
    begin
        pad_row = PAD_W'(row);
        for (int l = 0; l < LEAVES; l++)
        begin
            node_en[LEAVES + l]    = (l < MAX_WAYS) && (CNT_W'(l) < ways);
            node_stamp[LEAVES + l] = pad_row[l].stamp;
            node_way[LEAVES + l]   = WAY_W'(l);
        end
        for (int i = LEAVES - 1; i >= 1; i--)
        begin
            if (!node_en[2*i] || (node_en[2*i+1] && (node_stamp[2*i+1] < node_stamp[2*i])))
            begin
                node_en[i]    = node_en[2*i+1];
                node_stamp[i] = node_stamp[2*i+1];
                node_way[i]   = node_way[2*i+1];
            end
            else
            begin
                node_en[i]    = node_en[2*i];
                node_stamp[i] = node_stamp[2*i];
                node_way[i]   = node_way[2*i];
            end
        end
        victim_way  = node_way[1];
        victim_used = (node_stamp[1] != '0);
    end

endmodule

@@ src/set_assoc_lru_cache_model_unit.sv @@
// Top level of the set-associative LRU cache model: control, counters and config.
//
// Usage:
//   Access channel: drive req (mode, address) with start high; the beat is taken
//   at a rising edge where start is high and busy is low.
//   Result channel: rsp is valid for exactly one cycle while done is high;
//   done and rsp are registered from the lookup state that follows the access
//   beat. The receiver cannot stall; a result is registered and shown once.
//   Accesses do not overlap. The set row is read from the set store at the
//   accept edge, compared, LRU-searched and written back in the next cycle,
//   and busy holds off the next access for that cycle.
//   Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
//   is always high. Write registers only while no access is in flight.
//   Mode 3 performs no lookup: flags are 0 and totals are unchanged.
//   Reset: counters and config registers reset (ways in use to 1), then a
//   clearing pass writes every set row to zero, one row a cycle, over all
//   2**MAX_SET_BITS rows (64 by default); busy stays high during the pass.
module set_assoc_lru_cache_model_unit #(
    parameter int MAX_SET_BITS = sacl_pkg::DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = sacl_pkg::DEF_MAX_WAYS,
    parameter int ADDR_WIDTH   = sacl_pkg::DEF_ADDR_WIDTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  sacl_pkg::req_t req,
    output logic           done,
    output sacl_pkg::rsp_t rsp,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [1:0]     cfg_index,
    input  logic [7:0]     cfg_data
);

    localparam int DEPTH = 1 << MAX_SET_BITS;
    localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WCNT_W = $clog2(MAX_WAYS + 1);
    localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int ROW_W = MAX_WAYS * sacl_pkg::ENTRY_W;

    sacl_pkg::sacl_state_t state_reg, state_next;

    logic [2:0]  set_bits_reg;
    logic [4:0]  block_bits_reg;
    logic [3:0]  ways_in_use_reg;

    logic [1:0]                   mode_reg;
    logic [SET_W-1:0]             set_reg;
    logic [sacl_pkg::TAG_W-1:0]   tag_reg;
    logic [WCNT_W-1:0]            ways_reg;
    logic [SET_W-1:0]             clr_idx_reg;

    logic [sacl_pkg::STAMP_W-1:0] stamp_reg, stamp_next;
    logic [sacl_pkg::CNT_W-1:0]   hit_reg, hit_next;
    logic [sacl_pkg::CNT_W-1:0]   miss_reg, miss_next;
    logic [sacl_pkg::CNT_W-1:0]   evict_reg, evict_next;

    logic           done_reg;
    sacl_pkg::rsp_t rsp_reg, rsp_next;

    logic                       accept;
    logic [31:0]                addr_mask;
    logic [31:0]                addr_m;
    logic [3:0]                 sb_eff;
    logic [5:0]                 shift_n;
    logic [31:0]                set_shift;
    logic [SET_W-1:0]           set_mask;
    logic [SET_W-1:0]           set_in;
    logic [31:0]                tag_in;
    logic [5:0]                 ways6;
    logic [WCNT_W-1:0]          ways_in;

    logic                       mem_we;
    logic [SET_W-1:0]           mem_waddr;
    logic [ROW_W-1:0]           mem_wdata;
    logic [ROW_W-1:0]           mem_rdata;

    sacl_pkg::line_entry_t [MAX_WAYS-1:0] row_rd;
    sacl_pkg::line_entry_t [MAX_WAYS-1:0] row_wr;

    logic             hit;
    logic [WAY_W-1:0] hit_way;
    logic [WAY_W-1:0] victim_way;
    logic             victim_used;
    logic [WAY_W-1:0] sel_way;
    logic             mode_ok;
    logic             is_mod;
    logic             ev;
    logic [sacl_pkg::STAMP_W-1:0] new_stamp;

    assign accept    = start && !busy;
    assign busy      = (state_reg != sacl_pkg::S_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign rsp       = rsp_reg;

    // Address split from the incoming beat, using the current configuration.
    always_comb
    begin
        for (int b = 0; b < 32; b++)
        begin
            addr_mask[b] = (b < ADDR_WIDTH);
        end
        addr_m = req.address & addr_mask;
        if ({1'b0, set_bits_reg} > 4'(MAX_SET_BITS))
        begin
            sb_eff = 4'(MAX_SET_BITS);
        end
        else
        begin
            sb_eff = {1'b0, set_bits_reg};
        end
        shift_n   = 6'(sb_eff) + 6'(block_bits_reg);
        set_shift = addr_m >> block_bits_reg;
        for (int b = 0; b < SET_W; b++)
        begin
            set_mask[b] = (b < int'(sb_eff));
        end
        set_in = set_shift[SET_W-1:0] & set_mask;
        tag_in = addr_m >> shift_n;
        ways6  = 6'(ways_in_use_reg);
        if (ways6 == 6'd0)
        begin
            ways_in = WCNT_W'(1);
        end
        else if (ways6 > 6'(MAX_WAYS))
        begin
            ways_in = WCNT_W'(MAX_WAYS);
        end
        else
        begin
            ways_in = WCNT_W'(ways6);
        end
    end

    sacl_set_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (SET_W),
        .DATA_W (ROW_W)
    ) u_set_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (accept),
        .raddr (set_in),
        .rdata (mem_rdata)
    );

    assign row_rd = mem_rdata;

    sacl_way_select #(
        .MAX_WAYS (MAX_WAYS),
        .CNT_W    (WCNT_W),
        .WAY_W    (WAY_W)
    ) u_way_select (
        .row         (row_rd),
        .tag         (tag_reg),
        .ways        (ways_reg),
        .hit         (hit),
        .hit_way     (hit_way),
        .victim_way  (victim_way),
        .victim_used (victim_used)
    );

    // Update of the looked-up set; a modify's second lookup restamps the same way.
    always_comb
    begin
        mode_ok = (mode_reg == sacl_pkg::MODE_LOAD) || (mode_reg == sacl_pkg::MODE_STORE)
               || (mode_reg == sacl_pkg::MODE_MODIFY);
        is_mod  = (mode_reg == sacl_pkg::MODE_MODIFY);
        sel_way = hit ? hit_way : victim_way;
        ev      = !hit && victim_used;
        new_stamp = stamp_reg + (is_mod ? 32'd2 : 32'd1);

        row_wr = row_rd;
        row_wr[sel_way].valid = 1'b1;
        row_wr[sel_way].tag   = tag_reg;
        row_wr[sel_way].stamp = new_stamp;

        stamp_next = stamp_reg;
        hit_next   = hit_reg;
        miss_next  = miss_reg;
        evict_next = evict_reg;
        if (mode_ok)
        begin
            stamp_next = new_stamp;
            hit_next   = hit_reg + 32'(hit) + 32'(is_mod);
            miss_next  = miss_reg + 32'(!hit);
            evict_next = evict_reg + 32'(ev);
        end

        rsp_next.first_hit      = mode_ok && hit;
        rsp_next.evicted        = mode_ok && ev;
        rsp_next.second_hit     = is_mod;
        rsp_next.hit_total      = hit_next;
        rsp_next.miss_total     = miss_next;
        rsp_next.eviction_total = evict_next;
    end

    always_comb
    begin
        state_next = state_reg;
        mem_we     = 1'b0;
        mem_waddr  = set_reg;
        mem_wdata  = row_wr;
        unique case (state_reg)
            sacl_pkg::S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_idx_reg;
                mem_wdata = '0;
                if (clr_idx_reg == SET_W'(DEPTH - 1))
                begin
                    state_next = sacl_pkg::S_IDLE;
                end
            end
            sacl_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = sacl_pkg::S_LOOKUP;
                end
            end
            sacl_pkg::S_LOOKUP:
            begin
                mem_we     = mode_ok;
                state_next = sacl_pkg::S_IDLE;
            end
            default:
            begin
                state_next = sacl_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= sacl_pkg::S_CLEAR;
            clr_idx_reg <= '0;
            done_reg    <= 1'b0;
            stamp_reg   <= '0;
            hit_reg     <= '0;
            miss_reg    <= '0;
            evict_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == sacl_pkg::S_LOOKUP);
            if (state_reg == sacl_pkg::S_CLEAR)
            begin
                clr_idx_reg <= clr_idx_reg + SET_W'(1);
            end
            if (state_reg == sacl_pkg::S_LOOKUP)
            begin
                stamp_reg <= stamp_next;
                hit_reg   <= hit_next;
                miss_reg  <= miss_next;
                evict_reg <= evict_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg    <= '0;
            block_bits_reg  <= '0;
            ways_in_use_reg <= 4'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                sacl_pkg::CFG_SET_BITS:    set_bits_reg    <= cfg_data[2:0];
                sacl_pkg::CFG_BLOCK_BITS:  block_bits_reg  <= cfg_data[4:0];
                sacl_pkg::CFG_WAYS_IN_USE: ways_in_use_reg <= cfg_data[3:0];
                default:
                begin
                end
            endcase
        end
    end

    // Capture the access beat; result payload follows the lookup cycle.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= req.mode;
            set_reg  <= set_in;
            tag_reg  <= tag_in;
            ways_reg <= ways_in;
        end
        if (state_reg == sacl_pkg::S_LOOKUP)
        begin
            rsp_reg <= rsp_next;
        end
    end

    a_done_after_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == sacl_pkg::S_LOOKUP))
        else $error("result strobe without a lookup cycle");

    a_evict_only_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.evicted |-> !rsp.first_hit)
        else $error("eviction reported on a hit");

    a_no_accept_in_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sacl_pkg::S_LOOKUP |=> state_reg == sacl_pkg::S_IDLE)
        else $error("lookup did not return to idle");

    a_second_hit_counts: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.second_hit && !rsp.first_hit |-> rsp.miss_total == $past(miss_reg) + 32'd1)
        else $error("modify miss not counted once");

endmodule
